/* design/bbs_pkg.sv */
// Package for the balanced bracket skipper: widths, character codes, status
// and quote codes, register map and the structs shared between its modules.
// No dependencies.
`default_nettype none

package bbs_pkg;

   localparam int CH_W       = 8;
   localparam int DEPTH_W    = 8;
   localparam int LINE_W     = 20;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CH_W-1:0] CH_NUL    = 8'h00;

   localparam logic [DEPTH_W-1:0] DEPTH_CAP  = 8'd255;
   localparam logic [LINE_W-1:0]  LINE_MAX   = 20'hFFFFF;
   localparam logic [LINE_W-1:0]  LINE_RESET = 20'd1;
   localparam logic [CH_W-1:0]    OPEN_RESET  = 8'd40;
   localparam logic [CH_W-1:0]    CLOSE_RESET = 8'd41;

   typedef enum logic [2:0] {
      ST_NOT_BLOCK  = 3'd0,
      ST_SCAN       = 3'd1,
      ST_CLOSED     = 3'd2,
      ST_NO_CLOSER  = 3'd3,
      ST_OPEN_QUOTE = 3'd4,
      ST_OVERFLOW   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      QK_NONE   = 2'd0,
      QK_SINGLE = 2'd1,
      QK_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic [1:0] {
      REG_OPEN  = 2'd0,
      REG_CLOSE = 2'd1,
      REG_START = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CH_W-1:0]   open_char;
      logic [CH_W-1:0]   close_char;
      logic [LINE_W-1:0] start_line;
      logic              line_load;
   } cfg_type;

   // status sits in the low bits when packed into tdata
   typedef struct packed {
      logic [LINE_W-1:0]  quote_line;
      logic [LINE_W-1:0]  line;
      quote_type          quote_mode;
      logic [DEPTH_W-1:0] depth;
      status_type         status;
   } result_type;

endpackage

`default_nettype wire

/* design/bbs_csr.sv */
// Configuration registers of the bracket skipper behind an APB-style port.
// Depends on bbs_pkg.
`default_nettype none

module bbs_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [bbs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output bbs_pkg::cfg_type                    cfg
);
   import bbs_pkg::*;

   logic [CH_W-1:0]   open_ff;
   logic [CH_W-1:0]   close_ff;
   logic [LINE_W-1:0] start_ff;
   logic              wr_en;
   reg_index_type     index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= OPEN_RESET;
         close_ff <= CLOSE_RESET;
         start_ff <= LINE_RESET;
      end else if (wr_en) begin
         case (index)
            REG_OPEN:  open_ff  <= csr_pwdata[CH_W-1:0];
            REG_CLOSE: close_ff <= csr_pwdata[CH_W-1:0];
            REG_START: start_ff <= csr_pwdata[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_OPEN:  csr_prdata = {{(CSR_DATA_W-CH_W){1'b0}}, open_ff};
         REG_CLOSE: csr_prdata = {{(CSR_DATA_W-CH_W){1'b0}}, close_ff};
         REG_START: csr_prdata = {{(CSR_DATA_W-LINE_W){1'b0}}, start_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // a start_line write also loads the line counter
   assign cfg.open_char  = open_ff;
   assign cfg.close_char = close_ff;
   assign cfg.start_line = csr_pwdata[LINE_W-1:0];
   assign cfg.line_load  = wr_en && (index == REG_START);

endmodule

`default_nettype wire

/* design/bbs_scan.sv */
// Scanner state and the one-character step: nesting depth, quote mode,
// escape, line counter and quote line. Depends on bbs_pkg.
`default_nettype none

module bbs_scan (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [bbs_pkg::CH_W-1:0] ch,
   input  wire bbs_pkg::cfg_type         cfg,
   output bbs_pkg::result_type           result
);
   import bbs_pkg::*;

   logic               scanning_ff, scanning_in;
   quote_type          quote_ff, quote_in;
   logic               escape_ff, escape_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [LINE_W-1:0]  qline_ff, qline_in;
   status_type         status;
   logic [CH_W-1:0]    closer;

   assign closer = (quote_ff == QK_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

   always_comb begin
      scanning_in = scanning_ff;
      quote_in    = quote_ff;
      escape_in   = escape_ff;
      depth_in    = depth_ff;
      line_in     = line_ff;
      qline_in    = qline_ff;
      status      = ST_SCAN;
      if (!scanning_ff) begin
         if (ch == cfg.open_char) begin
            scanning_in = 1'b1;
            depth_in    = '0;
            quote_in    = QK_NONE;
            escape_in   = 1'b0;
         end else begin
            status = ST_NOT_BLOCK;
         end
      end else if (quote_ff != QK_NONE) begin
         if (escape_ff) begin
            escape_in = 1'b0;
            if (ch == CH_NUL) begin
               scanning_in = 1'b0;
               status      = ST_OPEN_QUOTE;
            end
         end else if (ch == CH_BSLASH) begin
            escape_in = 1'b1;
         end else if (ch == closer) begin
            quote_in = QK_NONE;
         end else if (ch == CH_NUL) begin
            scanning_in = 1'b0;
            status      = ST_OPEN_QUOTE;
         end
      end else begin
         if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
            quote_in  = (ch == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
            qline_in  = line_ff;
            escape_in = 1'b0;
         end else if (ch == cfg.open_char) begin
            if (depth_ff >= DEPTH_CAP) begin
               depth_in = DEPTH_CAP;
               status   = ST_OVERFLOW;
            end else begin
               depth_in = depth_ff + 8'd1;
            end
         end else if (ch == cfg.close_char) begin
            if (depth_ff == '0) begin
               scanning_in = 1'b0;
               status      = ST_CLOSED;
            end else begin
               depth_in = depth_ff - 8'd1;
            end
         end else if (ch == CH_NUL) begin
            scanning_in = 1'b0;
            status      = ST_NO_CLOSER;
         end else if (ch == CH_NL && line_ff < LINE_MAX) begin
            line_in = line_ff + 20'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         quote_ff    <= QK_NONE;
         escape_ff   <= 1'b0;
         depth_ff    <= '0;
         qline_ff    <= '0;
      end else if (step) begin
         scanning_ff <= scanning_in;
         quote_ff    <= quote_in;
         escape_ff   <= escape_in;
         depth_ff    <= depth_in;
         qline_ff    <= qline_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= LINE_RESET;
      end else if (cfg.line_load) begin
         line_ff <= cfg.start_line;
      end else if (step) begin
         line_ff <= line_in;
      end
   end

   assign result.status     = status;
   assign result.depth      = depth_in;
   assign result.quote_mode = quote_in;
   assign result.line       = line_in;
   assign result.quote_line = qline_in;

   a_escape_in_quote: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (quote_ff != QK_NONE))
      else $error("escape pending outside quotes");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (step && !scanning_ff && ch != cfg.open_char) |=>
         ($stable(depth_ff) && $stable(quote_ff) && !scanning_ff))
      else $error("idle character changed scanner state");

   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (step && (status == ST_CLOSED || status == ST_NO_CLOSER ||
                status == ST_OPEN_QUOTE)) |=> !scanning_ff)
      else $error("block end did not stop scanning");

endmodule

`default_nettype wire

/* design/balanced_bracket_skipper_unit.sv */
// Balanced bracket skipper: takes one source character per request and skips
// one bracketed block, tracking nesting, quotes, escapes and line numbers; one
// result per request. Requests flow at one per cycle unless back pressure holds
// them: each character goes from an input register through the scanner step into
// a result register, and the scanner state updates as the character passes; back
// pressure on the result side only stalls once both registers are full.
// Depends on bbs_pkg, bbs_csr and bbs_scan.
`default_nettype none

module balanced_bracket_skipper_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [bbs_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] ch
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [2:0] status, [10:3] depth, [12:11] quote_mode, [32:13] line,
   // [52:33] quote_line, [55:53] zero
   output logic      [bbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [bbs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import bbs_pkg::*;

   cfg_type         cfg;
   result_type      result;
   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] in_ch_ff;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff;
   logic            move;
   logic            take;

   bbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbs_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (move),
      .ch     (in_ch_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign move       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ch_ff <= req_tdata[CH_W-1:0];
      end
      if (move) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(result_type)){1'b0}}, out_data_ff};

endmodule

`default_nettype wire
